// ===== hw/rtl/md5_pkg.sv =====
package md5_pkg;

  // Input word: one message byte or the end of the message
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } md5_in_t;

  // Output word: the four chaining words of the finished digest
  typedef struct packed {
    logic [31:0] digest_word_a;
    logic [31:0] digest_word_b;
    logic [31:0] digest_word_c;
    logic [31:0] digest_word_d;
  } md5_out_t;

  // Working or chaining register set
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_words_t;

  localparam md5_words_t MD5_IV = '{
    a: 32'h67452301,
    b: 32'hefcdab89,
    c: 32'h98badcfe,
    d: 32'h10325476
  };

  localparam logic       KIND_DATA  = 1'b0;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LEN_POS    = 7'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  // Per-round additive constants
  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, round mod 4}
  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round
  function automatic logic [3:0] md5_idx(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] res;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0:    res = lo;
      2'd1:    res = 4'(lo * 4'd5 + 4'd1);
      2'd2:    res = 4'(lo * 4'd3 + 4'd5);
      default: res = 4'(lo * 4'd7);
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/md5_block_buf.sv =====
module md5_block_buf
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_addr_i,
  input  logic [7:0]  wr_byte_i,
  input  logic [3:0]  rd_addr_i,
  output logic [31:0] rd_word_o
);

  logic [31:0] mem_q [16];
  logic [31:0] rd_word_q;

  // Write one byte lane; little-endian within each word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i[5:2]][{wr_addr_i[1:0], 3'b000} +: 8] <= wr_byte_i;
    end
  end

  // Registered word read
  always_ff @(posedge clk_i) begin
    rd_word_q <= mem_q[rd_addr_i];
  end

  assign rd_word_o = rd_word_q;

endmodule

// ===== hw/rtl/md5_round.sv =====
module md5_round
  import md5_pkg::*;
(
  input  logic [5:0]  round_i,
  input  md5_words_t  work_i,
  input  logic [31:0] msg_word_i,
  output md5_words_t  work_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rotated;
  logic [4:0]  shamt;

  // Select the round's boolean function
  always_comb begin
    unique case (round_i[5:4])
      2'd0:    f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      2'd1:    f = (work_i.d & work_i.b) | (~work_i.d & work_i.c);
      2'd2:    f = work_i.b ^ work_i.c ^ work_i.d;
      default: f = work_i.c ^ (work_i.b | ~work_i.d);
    endcase
  end

  // Add, rotate and fold into b; amounts are never zero
  assign shamt   = MD5_ROT[{round_i[5:4], round_i[1:0]}];
  assign sum     = work_i.a + f + MD5_K[round_i] + msg_word_i;
  assign rotated = (sum << shamt) | (sum >> (6'd32 - {1'b0, shamt}));

  // Shift the register set along
  assign work_o.a = work_i.d;
  assign work_o.b = work_i.b + rotated;
  assign work_o.c = work_i.b;
  assign work_o.d = work_i.c;

endmodule

// ===== hw/rtl/md5_message_digest.sv =====
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o  | md5_in_t  (kind, data_byte)
// out     | output    | out_valid_o/out_stall_i | md5_out_t (digest words A..D)
//
// The 64th byte of a block starts a compression: one read prefetch, 64 rounds through
// the shared round unit, then one chaining add; no byte is taken until it ends.
// An end word writes up to 72 padding bytes, one per cycle, runs one or two compressions
// and loads the output.
// Reset loads the initial vector and a zero count; the buffer is not cleared.
// A waiting digest lets the next message in; a second digest holds until the first is taken.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  md5_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output md5_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LEN,
    ST_PRE,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } state_e;

  state_e      state_q, state_d;
  md5_words_t  chain_q, chain_d;
  md5_words_t  work_q, work_d;
  md5_words_t  work_next;
  logic [60:0] count_q, count_d;
  logic [63:0] len_q, len_d;
  logic [6:0]  ptr_q, ptr_d;
  logic [5:0]  round_q, round_d;
  logic        pad_q, pad_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  md5_out_t    out_q, out_d;

  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [3:0]  rd_addr;
  logic [31:0] msg_word;

  md5_block_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_byte_i (wr_byte),
    .rd_addr_i (rd_addr),
    .rd_word_o (msg_word)
  );

  md5_round u_round (
    .round_i    (round_q),
    .work_i     (work_q),
    .msg_word_i (msg_word),
    .work_o     (work_next)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Prefetch the word for the next round
  assign rd_addr = (state_q == ST_ROUND) ? md5_idx(round_q + 6'd1) : md5_idx(6'd0);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    work_d      = work_q;
    count_d     = count_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    round_d     = round_q;
    pad_d       = pad_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = ptr_q[5:0];
    wr_byte     = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wr_en   = 1'b1;
          wr_addr = count_q[5:0];
          if (in_data_i.kind == KIND_DATA) begin
            wr_byte = in_data_i.data_byte;
            count_d = count_q + 61'd1;
            if (count_q[5:0] == LAST_BYTE) begin
              pad_d   = 1'b0;
              last_d  = 1'b0;
              state_d = ST_PRE;
            end
          end else begin
            wr_byte = PAD_BYTE;
            len_d   = {count_q, 3'b000};
            ptr_d   = {1'b0, count_q[5:0]} + 7'd1;
            pad_d   = 1'b1;
            last_d  = 1'b0;
            state_d = ST_FILL;
          end
        end
      end

      // Zero fill; compress an overflowing block or move on to the length
      ST_FILL: begin
        priority if (ptr_q[6]) begin
          state_d = ST_PRE;
        end else if (ptr_q == LEN_POS) begin
          state_d = ST_LEN;
        end else begin
          wr_en = 1'b1;
          ptr_d = ptr_q + 7'd1;
        end
      end

      // Write the bit length, least significant byte first
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = len_q[7:0];
        len_d   = len_q >> 8;
        ptr_d   = ptr_q + 7'd1;
        if (ptr_q[5:0] == LAST_BYTE) begin
          last_d  = 1'b1;
          state_d = ST_PRE;
        end
      end

      ST_PRE: begin
        work_d  = chain_q;
        round_d = 6'd0;
        state_d = ST_ROUND;
      end

      ST_ROUND: begin
        work_d  = work_next;
        round_d = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FINAL;
        end
      end

      // Fold the block into the chaining words
      ST_FINAL: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        priority if (last_q) begin
          state_d = ST_DONE;
        end else if (pad_q) begin
          ptr_d   = 7'd0;
          state_d = ST_FILL;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Hand the digest to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.digest_word_a = chain_q.a;
          out_d.digest_word_b = chain_q.b;
          out_d.digest_word_c = chain_q.c;
          out_d.digest_word_d = chain_q.d;
          out_valid_d = 1'b1;
          chain_d     = MD5_IV;
          count_d     = '0;
          pad_d       = 1'b0;
          last_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= MD5_IV;
      work_q      <= '0;
      count_q     <= '0;
      len_q       <= '0;
      ptr_q       <= '0;
      round_q     <= '0;
      pad_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      work_q      <= work_d;
      count_q     <= count_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      round_q     <= round_d;
      pad_q       <= pad_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule

// ===== dv/md5_checker.sv =====
`timescale 1ns / 1ps

module md5_checker
  import md5_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  md5_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  md5_out_t out_data_i,
  output int       digests_due_o,
  output int       mismatches_o
);

  localparam int         REPORT_LIMIT = 10;
  localparam int         BLOCK_LAST   = 63;
  localparam int         LEN_OFFSET   = 56;
  localparam logic [7:0] PAD_MARK     = 8'h80;

  localparam logic [31:0] CHAIN_SEED [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic [31:0] chain [4];
  logic [7:0]  block_bytes [64];
  logic [60:0] byte_total;
  md5_out_t    digest_q [$];
  int          mismatch_total;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Run the 64 rounds over the buffered block and fold into the chain
  task automatic compress_block();
    logic [31:0] msg_w [16];
    logic [31:0] a, b, c, d, f, t;
    int          g;
    for (int i = 0; i < 16; i++) begin
      msg_w[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                  block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + ROUND_ADD[r] + msg_w[g], ROUND_SHIFT[(r / 16) * 4 + r % 4]);
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endtask

  task automatic restart_chain();
    for (int k = 0; k < 4; k++) chain[k] = CHAIN_SEED[k];
    byte_total = '0;
  endtask

  // Store one message byte; compress once the block is full
  task automatic take_byte(input logic [7:0] value);
    int p;
    p = int'(byte_total[5:0]);
    block_bytes[p] = value;
    byte_total = byte_total + 1'b1;
    if (p == BLOCK_LAST) compress_block();
  endtask

  // Pad, append the bit length, compress and queue the digest
  task automatic close_message();
    logic [63:0] bit_len;
    md5_out_t    digest;
    int          p;
    bit_len = {byte_total, 3'b000};
    p = int'(byte_total[5:0]);
    block_bytes[p] = PAD_MARK;
    p++;
    if (p > LEN_OFFSET) begin
      while (p <= BLOCK_LAST) begin
        block_bytes[p] = '0;
        p++;
      end
      compress_block();
      p = 0;
    end
    while (p < LEN_OFFSET) begin
      block_bytes[p] = '0;
      p++;
    end
    for (int k = 0; k < 8; k++) block_bytes[LEN_OFFSET + k] = bit_len[8*k +: 8];
    compress_block();
    digest.digest_word_a = chain[0];
    digest.digest_word_b = chain[1];
    digest.digest_word_c = chain[2];
    digest.digest_word_d = chain[3];
    digest_q.insert(digest_q.size(), digest);
    restart_chain();
  endtask

  // Compare a delivered digest word by word against the oldest prediction
  task automatic check_digest(input md5_out_t got);
    md5_out_t want;
    if (digest_q.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT) $display("unexpected digest %h", got);
    end else begin
      want = digest_q.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[127-32*k -: 32] !== want[127-32*k -: 32]) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_LIMIT) begin
            $display("digest word %c: expected %h, got %h", 8'h41 + k,
                     want[127-32*k -: 32], got[127-32*k -: 32]);
          end
        end
      end
    end
  endtask

  // Watch both channels: drain results first, then advance the prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_chain();
      digest_q.delete();
      mismatch_total = 0;
      digests_due_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_digest(out_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.kind == KIND_DATA) take_byte(in_data_i.data_byte);
        else close_message();
      end
      digests_due_o <= digest_q.size();
      mismatches_o  <= mismatch_total;
    end
  end

endmodule

// ===== dv/tb_md5_message_digest.sv =====
`timescale 1ns / 1ps

module tb_md5_message_digest;
  import md5_pkg::*;

  localparam int   ITEM_TARGET   = 1750;
  localparam int   CYCLE_LIMIT   = 5_000_000;
  localparam int   SETTLE_CYCLES = 300;
  localparam logic KIND_END      = ~KIND_DATA;
  localparam int   BOUNDARY_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  md5_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  md5_out_t out_data;

  int       digests_due;
  int       mismatches;
  int       items_sent    = 0;
  int       cycle_count   = 0;
  int       send_idle_pct = 23;
  int       recv_idle_pct = 82;
  bit       send_calm     = 1'b0;
  bit       recv_calm     = 1'b0;
  logic [7:0] msg_bytes [$];

  always #1 clk = ~clk;

  md5_message_digest dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  md5_checker digest_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .digests_due_o (digests_due),
    .mismatches_o  (mismatches)
  );

  // Stall the digest side at random, with calm stretches now and then
  always @(posedge clk) begin
    if ($urandom_range(63) == 0) recv_calm <= ~recv_calm;
    out_stall <= !recv_calm && ($urandom_range(99) < recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one word, idling first unless calm, and hold it until taken
  task automatic send_word(input logic word_kind, input logic [7:0] value);
    if (!send_calm) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_data.kind      <= word_kind;
    in_data.data_byte <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_message(input logic [7:0] end_byte);
    foreach (msg_bytes[i]) send_word(KIND_DATA, msg_bytes[i]);
    send_word(KIND_END, end_byte);
  endtask

  // Hold off the sender until every digest has been delivered
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (digests_due != 0);
  endtask

  // Build a message, favouring lengths around the padding boundaries
  task automatic random_message();
    int         len;
    int         fill;
    logic [7:0] fill_byte;
    case ($urandom_range(9))
      0:       len = 0;
      1, 2:    len = BOUNDARY_LENS[$urandom_range(9)];
      default: len = $urandom_range(1, 70);
    endcase
    fill      = $urandom_range(15);
    send_calm = ($urandom_range(3) == 0);
    msg_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        0:       fill_byte = 8'h00;
        1:       fill_byte = 8'hff;
        default: fill_byte = 8'($urandom_range(255));
      endcase
      msg_bytes.insert(msg_bytes.size(), fill_byte);
    end
    send_message(8'($urandom_range(255)));
  endtask

  // Scatter stray words with a random kind
  task automatic noise_burst();
    repeat ($urandom_range(1, 16)) begin
      send_word(($urandom_range(3) == 0) ? KIND_END : KIND_DATA, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase_end;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, single extreme bytes, a short text, back-to-back ends
    msg_bytes.delete();
    send_message(8'hff);
    msg_bytes = '{8'h00};
    send_message(8'h00);
    msg_bytes = '{8'hff};
    send_message(8'h5a);
    msg_bytes = '{8'h61, 8'h62, 8'h63};
    send_message(8'h00);
    msg_bytes.delete();
    send_message(8'h00);
    send_message(8'hff);
    wait_for_digests();

    // Random: receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 23;
          recv_idle_pct <= 82;
        end
        1: begin
          send_idle_pct <= 82;
          recv_idle_pct <= 23;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (3 - phase);
      while (items_sent < phase_end) begin
        if ($urandom_range(7) == 0) noise_burst();
        else random_message();
        if ($urandom_range(19) == 0) wait_for_digests();
      end
      wait_for_digests();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && digests_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
